/* rtl/core/tbi_pkg.sv */
// ----------------------------------------------------------------------------
// tbi_pkg
// Shared types, constants and lookup functions of the terminal byte
// interpreter.
// ----------------------------------------------------------------------------
package tbi_pkg;

  localparam int unsigned MaxDim   = 256;
  localparam int unsigned SeqLimit = 63;
  localparam int unsigned DimW     = 9;
  localparam int unsigned QDepth   = 4;

  localparam logic [2:0] KindCell   = 3'd0;
  localparam logic [2:0] KindScroll = 3'd1;
  localparam logic [2:0] KindClear  = 3'd2;
  localparam logic [2:0] KindAlt    = 3'd3;
  localparam logic [2:0] KindMouse  = 3'd4;

  localparam logic [1:0] CfgRows = 2'd0;
  localparam logic [1:0] CfgCols = 2'd1;

  localparam logic [23:0] ColorWhite = 24'hFFFFFF;
  localparam logic [23:0] ColorBlack = 24'h000000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [20:0] codepoint;
    logic [1:0]  cell_width;
    logic [23:0] fore;
    logic [23:0] back;
    logic [4:0]  attr;
    logic        mode_on;
    logic        last;
  } res_t;

  // Results of one byte, packed from slot 0 upward
  typedef struct packed {
    logic [1:0]       n;
    res_t [2:0]       r;
  } res_bundle_t;

  function automatic logic [23:0] normal_color(logic [2:0] i);
    logic [23:0] c;
    unique case (i)
      3'd0: c = 24'h000000;
      3'd1: c = 24'hCD0000;
      3'd2: c = 24'h00CD00;
      3'd3: c = 24'hCDCD00;
      3'd4: c = 24'h0000EE;
      3'd5: c = 24'hCD00CD;
      3'd6: c = 24'h00CDCD;
      default: c = 24'hE5E5E5;
    endcase
    return c;
  endfunction

  function automatic logic [23:0] bright_color(logic [2:0] i);
    logic [23:0] c;
    unique case (i)
      3'd0: c = 24'h7F7F7F;
      3'd1: c = 24'hFF0000;
      3'd2: c = 24'h00FF00;
      3'd3: c = 24'hFFFE00;
      3'd4: c = 24'h5C5CFF;
      3'd5: c = 24'hFF00FF;
      3'd6: c = 24'h00FFFF;
      default: c = 24'hFFFFFF;
    endcase
    return c;
  endfunction

  function automatic logic is_wide(logic [20:0] cp);
    return (cp >= 21'h4E00 && cp <= 21'h9FFF) || (cp >= 21'h3400 && cp <= 21'h4DBF) ||
           (cp >= 21'h20000 && cp <= 21'h2A6DF) || (cp >= 21'hF900 && cp <= 21'hFAFF) ||
           (cp >= 21'hFF01 && cp <= 21'hFF60);
  endfunction

  function automatic logic [DimW-1:0] dim_of(logic [DimW-1:0] v);
    logic [DimW-1:0] d;
    if (v == '0) d = DimW'(1);
    else if (v > DimW'(MaxDim)) d = DimW'(MaxDim);
    else d = v;
    return d;
  endfunction

  function automatic logic [15:0] add_digit(logic [15:0] v, logic [3:0] dg);
    logic [19:0] t;
    t = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {16'd0, dg};
    return (t > 20'hFFFF) ? 16'hFFFF : t[15:0];
  endfunction

endpackage

/* rtl/core/tbi_core.sv */
// ----------------------------------------------------------------------------
// tbi_core
// Interpreter state and the single-pass decode of one byte into up to three
// screen commands.
// ----------------------------------------------------------------------------
module tbi_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     fire_i,
  input  logic [7:0]               byte_i,
  input  logic [tbi_pkg::DimW-1:0] rows_cfg_i,
  input  logic [tbi_pkg::DimW-1:0] cols_cfg_i,
  output tbi_pkg::res_bundle_t     res_o
);
  import tbi_pkg::*;

  typedef enum logic [2:0] {
    PhText = 3'b001,
    PhEsc  = 3'b010,
    PhCsi  = 3'b100
  } phase_e;

  localparam logic [2:0] StgIdle = 3'd0, StgSign1 = 3'd1, StgNum1 = 3'd2, StgSemi = 3'd3,
                         StgSign2 = 3'd4, StgNum2 = 3'd5, StgDone = 3'd6, StgNeg2 = 3'd7;
  localparam logic [2:0] PrgNone = 3'd0, PrgQ = 3'd1, PrgQ1 = 3'd2, PrgQ10 = 3'd3,
                         PrgQ104 = 3'd4, PrgQ100 = 3'd5, PrgAlt = 3'd6;

  phase_e      phase_q, phase_d;
  logic [1:0]  upend_q, upend_d;
  logic [20:0] uacc_q, uacc_d;
  logic [5:0]  seqlen_q, seqlen_d;
  logic [15:0] num1_q, num1_d, num2_q, num2_d;
  logic [2:0]  prog_q, prog_d, stage_q, stage_d;
  logic        mseen_q, mseen_d, neg_q, neg_d;
  logic [7:0]  row_q, row_d;
  logic [8:0]  col_q, col_d;
  logic [23:0] fore_q, fore_d, back_q, back_d;
  logic [4:0]  attr_q, attr_d;

  logic [DimW-1:0] rows, cols;

  always_comb begin
    logic [8:0]  r;
    logic [8:0]  c;
    logic [15:0] pr, pc;
    logic        do_nl, do_cell, em_s, em_m, em_c, wide, dig;
    logic [20:0] cp;
    logic [3:0]  dg;
    logic [2:0]  np;
    res_t        rs, rm, rc;
    logic [1:0]  k;

    rows = dim_of(rows_cfg_i);
    cols = dim_of(cols_cfg_i);
    phase_d = phase_q; upend_d = upend_q; uacc_d = uacc_q; seqlen_d = seqlen_q;
    num1_d = num1_q; num2_d = num2_q; prog_d = prog_q; stage_d = stage_q;
    mseen_d = mseen_q; neg_d = neg_q; col_d = col_q;
    fore_d = fore_q; back_d = back_q; attr_d = attr_q;
    do_nl = 1'b0; do_cell = 1'b0; em_s = 1'b0; em_m = 1'b0; em_c = 1'b0;
    cp = {13'd0, byte_i};
    dg = byte_i[3:0];
    dig = (byte_i >= 8'h30) && (byte_i <= 8'h39);
    pr = '0; pc = '0; np = PrgNone;
    rs = '0; rm = '0; rc = '0;

    // pull the cursor row back onto a shrunk screen
    r = ({1'b0, row_q} >= rows) ? rows - 9'd1 : {1'b0, row_q};

    if (phase_q == PhCsi) begin
      if (byte_i >= 8'h20 && byte_i <= 8'h3F) begin
        // track the mode pattern
        if (prog_q != PrgAlt) begin
          np = (byte_i == 8'h3F) ? PrgQ : PrgNone;
          if (prog_q == PrgQ && byte_i == 8'h31) np = PrgQ1;
          else if (prog_q == PrgQ1 && byte_i == 8'h30) np = PrgQ10;
          else if (prog_q == PrgQ10 && byte_i == 8'h34) np = PrgQ104;
          else if (prog_q == PrgQ10 && byte_i == 8'h30) np = PrgQ100;
          else if (prog_q == PrgQ104 && byte_i == 8'h39) np = PrgAlt;
          else if (prog_q == PrgQ100 && (byte_i == 8'h30 || byte_i == 8'h36)) begin
            mseen_d = 1'b1; np = PrgNone;
          end
          prog_d = np;
        end
        // parse the two leading numbers
        unique case (stage_q)
          StgIdle: begin
            if (byte_i == 8'h20) stage_d = StgIdle;
            else if (byte_i == 8'h2B) stage_d = StgSign1;
            else if (byte_i == 8'h2D) begin stage_d = StgSign1; neg_d = 1'b1; end
            else if (dig) begin stage_d = StgNum1; num1_d = add_digit(num1_q, dg); end
            else stage_d = StgDone;
          end
          StgSign1, StgNum1: begin
            if (dig) begin stage_d = StgNum1; num1_d = add_digit(num1_q, dg); end
            else if (stage_q == StgNum1 && byte_i == 8'h3B) stage_d = StgSemi;
            else stage_d = StgDone;
          end
          StgSemi: begin
            if (byte_i == 8'h20) stage_d = StgSemi;
            else if (byte_i == 8'h2B) stage_d = StgSign2;
            else if (byte_i == 8'h2D) stage_d = StgNeg2;
            else if (dig) begin stage_d = StgNum2; num2_d = add_digit(num2_q, dg); end
            else stage_d = StgDone;
          end
          StgSign2, StgNum2: begin
            if (dig) begin stage_d = StgNum2; num2_d = add_digit(num2_q, dg); end
            else stage_d = StgDone;
          end
          default: stage_d = stage_q;
        endcase
        seqlen_d = seqlen_q + 6'd1;
        if (seqlen_d >= 6'(SeqLimit)) phase_d = PhText;
      end else begin
        phase_d = PhText;
        // final byte
        if (byte_i == 8'h48 || byte_i == 8'h66) begin
          pr = (neg_q || num1_q == '0) ? 16'd0 : num1_q - 16'd1;
          pc = (stage_q == StgNeg2 || num2_q == '0) ? 16'd0 : num2_q - 16'd1;
          r = (pr >= {7'd0, rows}) ? rows - 9'd1 : pr[8:0];
          col_d = (pc >= {7'd0, cols}) ? cols - 9'd1 : pc[8:0];
        end else if (byte_i == 8'h4A) begin
          r = '0; col_d = '0; em_m = 1'b1; rm.kind = KindClear;
        end else if (byte_i == 8'h6D) begin
          if (!(neg_q && num1_q != '0)) begin
            if (num1_q == 16'd0) begin
              fore_d = ColorWhite; back_d = ColorBlack; attr_d = '0;
            end else if (num1_q == 16'd1) attr_d = attr_q | 5'b00001;
            else if (num1_q == 16'd3) attr_d = attr_q | 5'b00010;
            else if (num1_q == 16'd4) attr_d = attr_q | 5'b00100;
            else if (num1_q == 16'd7) attr_d = attr_q | 5'b01000;
            else if (num1_q == 16'd9) attr_d = attr_q | 5'b10000;
            else if (num1_q >= 16'd30 && num1_q <= 16'd37)
              fore_d = normal_color(3'(num1_q - 16'd30));
            else if (num1_q >= 16'd90 && num1_q <= 16'd97)
              fore_d = bright_color(3'(num1_q - 16'd90));
            else if (num1_q >= 16'd40 && num1_q <= 16'd47)
              back_d = normal_color(3'(num1_q - 16'd40));
          end
        end else if (byte_i == 8'h68 || byte_i == 8'h6C) begin
          rm.mode_on = (byte_i == 8'h68);
          if (prog_q == PrgAlt) begin em_m = 1'b1; rm.kind = KindAlt; end
          else if (mseen_q) begin em_m = 1'b1; rm.kind = KindMouse; end
        end
      end
    end else if (upend_q != 2'd0) begin
      uacc_d = {uacc_q[14:0], byte_i[5:0]};
      upend_d = upend_q - 2'd1;
      cp = uacc_d;
      do_cell = (upend_d == 2'd0);
    end else if (phase_q == PhEsc && byte_i == 8'h5B) begin
      phase_d = PhCsi; seqlen_d = '0; num1_d = '0; num2_d = '0;
      prog_d = PrgNone; stage_d = StgIdle; mseen_d = 1'b0; neg_d = 1'b0;
    end else begin
      phase_d = PhText;
      if (byte_i == 8'h1B) phase_d = PhEsc;
      else if (byte_i == 8'h0D) col_d = '0;
      else if (byte_i == 8'h0A) do_nl = 1'b1;
      else if (byte_i == 8'h08 || byte_i == 8'h7F) begin
        if (col_q != '0) col_d = col_q - 9'd1;
      end else if (byte_i[7:5] == 3'b110) begin upend_d = 2'd1; uacc_d = {16'd0, byte_i[4:0]}; end
      else if (byte_i[7:4] == 4'b1110) begin upend_d = 2'd2; uacc_d = {17'd0, byte_i[3:0]}; end
      else if (byte_i[7:3] == 5'b11110) begin upend_d = 2'd3; uacc_d = {18'd0, byte_i[2:0]}; end
      else do_cell = 1'b1;
    end

    // wrap at the right edge
    c = col_d;
    if (do_cell && col_q >= cols) begin
      c = '0; do_nl = 1'b1;
    end
    // advance a row, scroll at the bottom
    if (do_nl) begin
      if (r + 9'd1 >= rows) begin em_s = 1'b1; r = rows - 9'd1; end
      else r = r + 9'd1;
    end
    wide = is_wide(cp);
    if (do_cell) begin
      em_m = 1'b1;
      rm.kind = KindCell; rm.row = r[7:0]; rm.col = c[7:0]; rm.codepoint = cp;
      rm.cell_width = wide ? 2'd2 : 2'd1; rm.attr = attr_q;
      em_c = wide && (c + 9'd1 < cols);
      rc.kind = KindCell; rc.row = r[7:0]; rc.col = 8'(c + 9'd1); rc.attr = attr_q;
      c = c + (wide ? 9'd2 : 9'd1);
    end
    col_d = c;
    row_d = r[7:0];

    rs.kind = KindScroll;
    rs.fore = fore_q; rs.back = back_q;
    rm.fore = fore_q; rm.back = back_q;
    rc.fore = fore_q; rc.back = back_q;
    rs.last = !em_m && !em_c;
    rm.last = !em_c;
    rc.last = 1'b1;

    // pack results from slot 0
    res_o = '0;
    k = 2'd0;
    if (em_s) begin res_o.r[k] = rs; k = k + 2'd1; end
    if (em_m) begin res_o.r[k] = rm; k = k + 2'd1; end
    if (em_c) begin res_o.r[k] = rc; k = k + 2'd1; end
    res_o.n = k;
  end

  // commit state on each processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhText; upend_q <= '0; uacc_q <= '0; seqlen_q <= '0;
      num1_q <= '0; num2_q <= '0; prog_q <= PrgNone; stage_q <= StgIdle;
      mseen_q <= 1'b0; neg_q <= 1'b0; row_q <= '0; col_q <= '0;
      fore_q <= ColorWhite; back_q <= ColorBlack; attr_q <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d; upend_q <= upend_d; uacc_q <= uacc_d; seqlen_q <= seqlen_d;
      num1_q <= num1_d; num2_q <= num2_d; prog_q <= prog_d; stage_q <= stage_d;
      mseen_q <= mseen_d; neg_q <= neg_d; row_q <= row_d; col_q <= col_d;
      fore_q <= fore_d; back_q <= back_d; attr_q <= attr_d;
    end
  end

endmodule

/* rtl/core/terminal_byte_interpreter.sv */
// ----------------------------------------------------------------------------
// terminal_byte_interpreter
// Turns a terminal byte stream (UTF-8 text, CR/LF/BS, CSI sequences) into
// screen commands: cell writes, scroll-ups, clears and mode changes.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  --------+--------------------------+-------------------------------------
//  in      | in_valid_i / in_stall_o  | byte_in_i
//  out     | out_valid_o / out_stall_i| kind_o row_o col_o codepoint_o ...
//  cfg     | cfg_valid_i / cfg_ready_o| cfg_index_i cfg_data_i
//
//  A byte is decoded combinationally from the input register and its 0..3
//  results enter a 4-entry output queue; while the output is not stalled, one
//  result leaves per cycle and one byte per cycle is sustained while each byte
//  yields at most one result; later bytes wait while larger bursts drain.
//  Reset clears the cursor, colors, parser and queue; screen is 24 x 80.
//  A stalled output holds the queue head; the input stalls when the queue
//  cannot take three more results.
// ----------------------------------------------------------------------------
module terminal_byte_interpreter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  row_o,
  output logic [7:0]  col_o,
  output logic [20:0] codepoint_o,
  output logic [1:0]  cell_width_o,
  output logic [23:0] fore_color_o,
  output logic [23:0] back_color_o,
  output logic [4:0]  attr_bits_o,
  output logic        mode_on_o,
  output logic        last_of_run_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [tbi_pkg::DimW-1:0] cfg_data_i
);
  import tbi_pkg::*;

  logic            in_valid_q;
  logic [7:0]      byte_q;
  logic [DimW-1:0] rows_q, cols_q;
  res_t [QDepth-1:0] q_q, q_d;
  logic [2:0]      cnt_q, cnt_d;
  logic            pop, fire;
  logic [2:0]      base;
  res_bundle_t     res;

  assign cfg_ready_o = 1'b1;
  assign pop  = out_valid_o && !out_stall_i;
  assign base = cnt_q - {2'b00, pop};
  assign fire = in_valid_q && (base <= 3'd1);
  assign in_stall_o = in_valid_q && !fire;

  // hold the screen size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DimW'(24);
      cols_q <= DimW'(80);
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CfgRows) rows_q <= cfg_data_i;
      else if (cfg_index_i == CfgCols) cols_q <= cfg_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) byte_q <= byte_in_i;
  end

  tbi_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .byte_i     (byte_q),
    .rows_cfg_i (rows_q),
    .cols_cfg_i (cols_q),
    .res_o      (res)
  );

  // shift out the head, append new results
  always_comb begin
    q_d = q_q;
    if (pop) begin
      for (int i = 0; i < QDepth - 1; i++) q_d[i] = q_q[i+1];
    end
    cnt_d = base;
    if (fire) begin
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < res.n) q_d[2'(base + 3'(k))] = res.r[k];
      end
      cnt_d = base + {1'b0, res.n};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign out_valid_o   = (cnt_q != 3'd0);
  assign kind_o        = q_q[0].kind;
  assign row_o         = q_q[0].row;
  assign col_o         = q_q[0].col;
  assign codepoint_o   = q_q[0].codepoint;
  assign cell_width_o  = q_q[0].cell_width;
  assign fore_color_o  = q_q[0].fore;
  assign back_color_o  = q_q[0].back;
  assign attr_bits_o   = q_q[0].attr;
  assign mode_on_o     = q_q[0].mode_on;
  assign last_of_run_o = q_q[0].last;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(QDepth)) else $error("output queue overfilled");
  a_byte_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !fire |=> in_valid_q && $stable(byte_q))
    else $error("pending byte lost");
  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(q_q[0]))
    else $error("stalled result changed");

endmodule

/* bench/terminal_byte_interpreter_test.sv */
// ----------------------------------------------------------------------------
// terminal_byte_interpreter_test
// Self-checking bench for the terminal byte interpreter. Bytes go in through
// the stall handshake while a local model of the cursor, colors and escape
// parser predicts every screen command; results are checked field by field
// in order. Runs a directed list, then random text, UTF-8 and CSI traffic
// over several screen sizes with random idling and backpressure.
// ----------------------------------------------------------------------------
module terminal_byte_interpreter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tbi_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned DrainWait  = 12;
  localparam logic [7:0]  AsciiEsc   = 8'h1B;

  logic        clk;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  byte_in;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  row;
  logic [7:0]  col;
  logic [20:0] codepoint;
  logic [1:0]  cell_width;
  logic [23:0] fore_color;
  logic [23:0] back_color;
  logic [4:0]  attr_bits;
  logic        mode_on;
  logic        last_of_run;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [DimW-1:0] cfg_data;

  terminal_byte_interpreter DUT (
    .clk_i(clk), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .byte_in_i(byte_in),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .kind_o(kind), .row_o(row), .col_o(col), .codepoint_o(codepoint),
    .cell_width_o(cell_width), .fore_color_o(fore_color), .back_color_o(back_color),
    .attr_bits_o(attr_bits), .mode_on_o(mode_on), .last_of_run_o(last_of_run),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // Screen model state
  logic [DimW-1:0] rows_reg, cols_reg;
  logic [8:0]  cur_row, cur_col;
  logic [23:0] cur_fore, cur_back;
  logic [4:0]  cur_attrs;
  logic        alt_on, mouse_on;
  logic [1:0]  esc_phase;
  logic [1:0]  u8_left;
  logic [20:0] u8_code;
  logic [5:0]  csi_len;
  logic [15:0] num_first, num_second;
  logic [7:0]  csi_flags;
  int          burst_count;

  res_t        screen_cmds_q[$];
  logic [7:0]  byte_plan_q[$];

  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned checked = 0;
  int unsigned bytes_sent = 0;
  int unsigned scrolls_seen = 0;
  int unsigned wides_seen = 0;
  int unsigned modes_seen = 0;
  bit          idle_on = 1'b1;
  int unsigned hold_left = 0;

  logic [23:0] dim_table [8] = '{24'h000000, 24'hCD0000, 24'h00CD00, 24'hCDCD00,
                                 24'h0000EE, 24'hCD00CD, 24'h00CDCD, 24'hE5E5E5};
  logic [23:0] lit_table [8] = '{24'h7F7F7F, 24'hFF0000, 24'h00FF00, 24'hFFFE00,
                                 24'h5C5CFF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF};

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, screen_cmds_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model
  function automatic int unsigned eff_dim(logic [DimW-1:0] v);
    if (v == 0) return 1;
    if (v > MaxDim) return MaxDim;
    return v;
  endfunction

  function automatic bit two_cells(logic [20:0] cp);
    return (cp >= 21'h4E00 && cp <= 21'h9FFF) || (cp >= 21'h3400 && cp <= 21'h4DBF) ||
           (cp >= 21'h20000 && cp <= 21'h2A6DF) || (cp >= 21'hF900 && cp <= 21'hFAFF) ||
           (cp >= 21'hFF01 && cp <= 21'hFF60);
  endfunction

  function automatic logic [15:0] push_digit(logic [15:0] v, logic [7:0] b);
    int unsigned t;
    t = v * 10 + (b - "0");
    return (t > 16'hFFFF) ? 16'hFFFF : t[15:0];
  endfunction

  function void model_reset();
    rows_reg = 9'd24; cols_reg = 9'd80;
    cur_row = '0; cur_col = '0;
    cur_fore = ColorWhite; cur_back = ColorBlack; cur_attrs = '0;
    alt_on = 1'b0; mouse_on = 1'b0;
    esc_phase = '0; u8_left = '0; u8_code = '0;
    csi_len = '0; num_first = '0; num_second = '0; csi_flags = '0;
  endfunction

  function void emit_cmd(logic [2:0] k, logic [8:0] r, logic [8:0] c, logic [20:0] cp,
                         logic [1:0] w, logic [4:0] a, logic m);
    res_t e;
    if (burst_count >= 3) return;
    e = '{kind: k, row: r[7:0], col: c[7:0], codepoint: cp, cell_width: w,
          fore: cur_fore, back: cur_back, attr: a, mode_on: m, last: 1'b0};
    screen_cmds_q.push_back(e);
    burst_count++;
  endfunction

  function void line_feed();
    int unsigned nrows;
    nrows = eff_dim(rows_reg);
    cur_row++;
    if (cur_row >= nrows) begin
      emit_cmd(KindScroll, 0, 0, 0, 0, 0, 0);
      cur_row = nrows - 1;
    end
  endfunction

  function void put_char(logic [20:0] cp);
    int unsigned ncols;
    logic [1:0]  w;
    ncols = eff_dim(cols_reg);
    w = two_cells(cp) ? 2'd2 : 2'd1;
    if (cur_col >= ncols) begin
      cur_col = 0;
      line_feed();
    end
    emit_cmd(KindCell, cur_row, cur_col, cp, w, cur_attrs, 0);
    if (w == 2 && cur_col + 1 < ncols)
      emit_cmd(KindCell, cur_row, cur_col + 1, 0, 0, cur_attrs, 0);
    cur_col += w;
  endfunction

  // Track the mode pattern and the number grammar of one parameter byte
  function void take_param(logic [7:0] b);
    logic [2:0] prog, np, stage;
    bit         dig;
    prog = csi_flags[2:0];
    stage = csi_flags[6:4];
    dig = (b >= "0" && b <= "9");
    if (prog != 6) begin
      np = (b == "?") ? 3'd1 : 3'd0;
      if (prog == 1 && b == "1") np = 2;
      else if (prog == 2 && b == "0") np = 3;
      else if (prog == 3 && b == "4") np = 4;
      else if (prog == 3 && b == "0") np = 5;
      else if (prog == 4 && b == "9") np = 6;
      else if (prog == 5 && (b == "0" || b == "6")) begin
        csi_flags[3] = 1'b1;
        np = 0;
      end
      prog = np;
    end
    case (stage)
      3'd0: begin
        if (b == " ") ;
        else if (b == "+") stage = 1;
        else if (b == "-") begin
          stage = 1; csi_flags[7] = 1'b1;
        end else if (dig) begin
          stage = 2; num_first = push_digit(num_first, b);
        end else stage = 6;
      end
      3'd1, 3'd2: begin
        if (dig) begin
          stage = 2; num_first = push_digit(num_first, b);
        end else if (stage == 2 && b == ";") stage = 3;
        else stage = 6;
      end
      3'd3: begin
        if (b == " ") ;
        else if (b == "+") stage = 4;
        else if (b == "-") stage = 7;
        else if (dig) begin
          stage = 5; num_second = push_digit(num_second, b);
        end else stage = 6;
      end
      3'd4, 3'd5: begin
        if (dig) begin
          stage = 5; num_second = push_digit(num_second, b);
        end else stage = 6;
      end
      default: ;
    endcase
    csi_flags = {csi_flags[7], stage, csi_flags[3], prog};
  endfunction

  function void apply_rendition();
    logic [15:0] code;
    code = num_first;
    if (csi_flags[7] && code != 0) return;
    if (code == 0) begin
      cur_fore = ColorWhite; cur_back = ColorBlack; cur_attrs = '0;
    end else if (code == 1) cur_attrs[0] = 1'b1;
    else if (code == 3) cur_attrs[1] = 1'b1;
    else if (code == 4) cur_attrs[2] = 1'b1;
    else if (code == 7) cur_attrs[3] = 1'b1;
    else if (code == 9) cur_attrs[4] = 1'b1;
    else if (code >= 30 && code <= 37) cur_fore = dim_table[code - 30];
    else if (code >= 90 && code <= 97) cur_fore = lit_table[code - 90];
    else if (code >= 40 && code <= 47) cur_back = dim_table[code - 40];
  endfunction

  function void finish_csi(logic [7:0] b);
    int unsigned nrows, ncols, r, c;
    nrows = eff_dim(rows_reg);
    ncols = eff_dim(cols_reg);
    if (b == "H" || b == "f") begin
      r = (csi_flags[7] || num_first == 0) ? 0 : num_first - 1;
      c = (csi_flags[6:4] == 7 || num_second == 0) ? 0 : num_second - 1;
      cur_row = (r >= nrows) ? nrows - 1 : r;
      cur_col = (c >= ncols) ? ncols - 1 : c;
    end else if (b == "J") begin
      cur_row = 0; cur_col = 0;
      emit_cmd(KindClear, 0, 0, 0, 0, 0, 0);
    end else if (b == "m") begin
      apply_rendition();
    end else if (b == "h" || b == "l") begin
      if (csi_flags[2:0] == 6) begin
        alt_on = (b == "h");
        emit_cmd(KindAlt, 0, 0, 0, 0, 0, b == "h");
      end else if (csi_flags[3]) begin
        mouse_on = (b == "h");
        emit_cmd(KindMouse, 0, 0, 0, 0, 0, b == "h");
      end
    end
  endfunction

  // Work out the screen commands of one accepted byte
  function void predict_commands(logic [7:0] b);
    int unsigned nrows;
    nrows = eff_dim(rows_reg);
    burst_count = 0;
    if (cur_row >= nrows) cur_row = nrows - 1;
    if (esc_phase == 2) begin
      if (b >= 8'h20 && b <= 8'h3F) begin
        take_param(b);
        csi_len++;
        if (csi_len >= SeqLimit) esc_phase = 0;
      end else begin
        esc_phase = 0;
        finish_csi(b);
      end
    end else if (u8_left != 0) begin
      u8_code = {u8_code[14:0], b[5:0]};
      u8_left--;
      if (u8_left == 0) put_char(u8_code);
    end else if (esc_phase == 1 && b == "[") begin
      esc_phase = 2;
      csi_len = '0; num_first = '0; num_second = '0; csi_flags = '0;
    end else begin
      esc_phase = 0;
      if (b == AsciiEsc) esc_phase = 1;
      else if (b == 8'h0D) cur_col = 0;
      else if (b == 8'h0A) line_feed();
      else if (b == 8'h08 || b == 8'h7F) begin
        if (cur_col > 0) cur_col--;
      end else if (b[7:5] == 3'b110) begin
        u8_left = 1; u8_code = b[4:0];
      end else if (b[7:4] == 4'b1110) begin
        u8_left = 2; u8_code = b[3:0];
      end else if (b[7:3] == 5'b11110) begin
        u8_left = 3; u8_code = b[2:0];
      end else put_char(b);
    end
    if (burst_count > 0) screen_cmds_q[$].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- checking
  function void report(string what, logic [23:0] exp_v, logic [23:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at cycle %0d: %s expected %0h got %0h", cycles, what, exp_v, got_v);
  endfunction

  function void compare_cmd(res_t e, res_t g);
    if (e.kind != g.kind) report("kind", e.kind, g.kind);
    if (e.row != g.row) report("row", e.row, g.row);
    if (e.col != g.col) report("col", e.col, g.col);
    if (e.codepoint != g.codepoint) report("codepoint", e.codepoint, g.codepoint);
    if (e.cell_width != g.cell_width) report("cell_width", e.cell_width, g.cell_width);
    if (e.fore != g.fore) report("fore_color", e.fore, g.fore);
    if (e.back != g.back) report("back_color", e.back, g.back);
    if (e.attr != g.attr) report("attr_bits", e.attr, g.attr);
    if (e.mode_on != g.mode_on) report("mode_on", e.mode_on, g.mode_on);
    if (e.last != g.last) report("last_of_run", e.last, g.last);
  endfunction

  // Check every accepted result against the oldest expectation
  always @(posedge clk) begin
    res_t got;
    if (rst_ni && out_valid && !out_stall) begin
      got = '{kind: kind, row: row, col: col, codepoint: codepoint, cell_width: cell_width,
              fore: fore_color, back: back_color, attr: attr_bits, mode_on: mode_on,
              last: last_of_run};
      if (screen_cmds_q.size() == 0) begin
        report("unexpected result, kind", 0, kind);
      end else begin
        compare_cmd(screen_cmds_q.pop_front(), got);
        checked++;
        if (kind == KindScroll) scrolls_seen++;
        if (cell_width == 2) wides_seen++;
        if (kind == KindAlt || kind == KindMouse) modes_seen++;
      end
    end
  end

  // Output backpressure: random bursts, plus a long hold on request
  initial begin
    int unsigned burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 18) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- driving
  task automatic send_byte(logic [7:0] b);
    @(negedge clk);
    in_valid <= 1'b1;
    byte_in <= b;
    do @(posedge clk); while (in_stall);
    predict_commands(b);
    bytes_sent++;
  endtask

  task automatic sender_gap(int unsigned n);
    @(negedge clk);
    in_valid <= 1'b0;
    byte_in <= $urandom;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain();
    sender_gap(1);
    while (screen_cmds_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [DimW-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CfgRows) rows_reg = v;
    else if (idx == CfgCols) cols_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- stimulus
  function void plan_text(string s);
    foreach (s[i]) byte_plan_q.push_back(s[i]);
  endfunction

  function void plan_utf8(logic [20:0] cp);
    if (cp < 21'h800) begin
      byte_plan_q.push_back({3'b110, cp[10:6]});
    end else if (cp < 21'h10000) begin
      byte_plan_q.push_back({4'b1110, cp[15:12]});
      byte_plan_q.push_back({2'b10, cp[11:6]});
    end else begin
      byte_plan_q.push_back({5'b11110, cp[20:18]});
      byte_plan_q.push_back({2'b10, cp[17:12]});
      byte_plan_q.push_back({2'b10, cp[11:6]});
    end
    byte_plan_q.push_back({2'b10, cp[5:0]});
  endfunction

  function string rand_number();
    string s;
    case ($urandom_range(0, 7))
      0: s = "";
      1: s = $sformatf("%0d", $urandom_range(65530, 99999));
      2: s = $sformatf(" -%0d", $urandom_range(0, 20));
      3: s = $sformatf("+%0d", $urandom_range(0, 300));
      default: s = $sformatf("%0d", $urandom_range(0, 260));
    endcase
    return s;
  endfunction

  // Queue one random chunk of the stream: mostly well-formed, some noise
  function void plan_chunk();
    int unsigned pick, n;
    logic [20:0] cp;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      n = $urandom_range(1, 6);
      repeat (n) byte_plan_q.push_back($urandom_range(8'h20, 8'h7E));
    end else if (pick < 40) begin
      byte_plan_q.push_back($urandom_range(0, 1) ? 8'h0A : 8'h0D);
    end else if (pick < 43) begin
      byte_plan_q.push_back($urandom_range(0, 1) ? 8'h08 : 8'h7F);
    end else if (pick < 55) begin
      case ($urandom_range(0, 5))
        0: cp = $urandom_range(21'h4E00, 21'h9FFF);
        1: cp = $urandom_range(21'h3400, 21'h4DBF);
        2: cp = $urandom_range(21'h20000, 21'h2A6DF);
        3: cp = $urandom_range(21'hF900, 21'hFAFF);
        4: cp = $urandom_range(21'hFF01, 21'hFF60);
        default: cp = $urandom_range(21'h80, 21'h1FFFFF);
      endcase
      plan_utf8(cp);
    end else if (pick < 62) begin
      plan_text({"\033[", rand_number(), ";", rand_number()});
      byte_plan_q.push_back($urandom_range(0, 1) ? "H" : "f");
    end else if (pick < 72) begin
      n = $urandom_range(0, 60);
      if (n > 47) n = 90 + $urandom_range(0, 9);
      plan_text({"\033[", ($urandom_range(0, 5) == 0) ? rand_number() :
                 $sformatf("%0d", n), "m"});
    end else if (pick < 75) begin
      plan_text({"\033[", rand_number(), "J"});
    end else if (pick < 83) begin
      case ($urandom_range(0, 4))
        0: plan_text("\033[?1049");
        1: plan_text("\033[?1000");
        2: plan_text("\033[?1006");
        3: plan_text("\033[?1000;?1049");
        default: begin
          plan_text("\033[?100");
          byte_plan_q.push_back($urandom_range(8'h30, 8'h39));
        end
      endcase
      byte_plan_q.push_back($urandom_range(0, 1) ? "h" : "l");
    end else if (pick < 88) begin
      // CSI with random parameter bytes, sometimes overlong
      plan_text("\033[");
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
      repeat (n) byte_plan_q.push_back($urandom_range(8'h20, 8'h3F));
      byte_plan_q.push_back($urandom_range(0, 3) == 0 ? AsciiEsc : $urandom_range(8'h40, 8'hFF));
    end else if (pick < 92) begin
      byte_plan_q.push_back(AsciiEsc);
      byte_plan_q.push_back($urandom);
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) byte_plan_q.push_back($urandom);
    end
  endfunction

  task automatic run_random(int unsigned items, bit no_gaps);
    int unsigned done;
    done = 0;
    while (done < items) begin
      if (byte_plan_q.size() == 0) plan_chunk();
      send_byte(byte_plan_q.pop_front());
      done++;
      if (!no_gaps && idle_on && $urandom_range(0, 7) == 0)
        sender_gap($urandom_range(1, 18));
    end
    while (byte_plan_q.size() != 0) send_byte(byte_plan_q.pop_front());
  endtask

  typedef struct {
    logic [7:0]  b;
    bit          typed;
    logic [2:0]  k;
    logic [7:0]  r;
    logic [7:0]  c;
    logic [20:0] cp;
    logic [1:0]  w;
    logic        m;
  } step_row_t;

  step_row_t directed_rows[$];

  function void row_plain(logic [7:0] b);
    directed_rows.push_back('{b, 1'b0, 0, 0, 0, 0, 0, 0});
  endfunction

  function void row_typed(logic [7:0] b, logic [2:0] k, logic [7:0] r, logic [7:0] c,
                          logic [20:0] cp, logic [1:0] w, logic m);
    directed_rows.push_back('{b, 1'b1, k, r, c, cp, w, m});
  endfunction

  typedef struct {
    logic [DimW-1:0] nrows;
    logic [DimW-1:0] ncols;
  } screen_size_t;

  initial begin
    screen_size_t sizes[6];
    string s;
    res_t e;
    sizes = '{'{9'd24, 9'd80}, '{9'd1, 9'd1}, '{9'd256, 9'd256}, '{9'd0, 9'd511},
              '{9'd3, 9'd5}, '{9'd511, 9'd0}};
    rst_ni = 1'b0;
    in_valid = 1'b0;
    byte_in = '0;
    cfg_valid = 1'b0;
    cfg_index = CfgRows;
    cfg_data = '0;
    model_reset();
    repeat (10) @(negedge clk);
    rst_ni <= 1'b1;

    // Directed: reset screen, extremes of the byte, cell, clear and alt-screen commands
    row_typed("A", KindCell, 0, 0, 21'h41, 1, 0);
    row_typed(8'h00, KindCell, 0, 1, 0, 1, 0);
    row_typed(8'hFF, KindCell, 0, 2, 21'hFF, 1, 0);
    s = "\033[2";
    foreach (s[i]) row_plain(s[i]);
    row_typed("J", KindClear, 0, 0, 0, 0, 0);
    s = "\033[?1049";
    foreach (s[i]) row_plain(s[i]);
    row_typed("h", KindAlt, 0, 0, 0, 0, 1);
    // SGR red, one wide character, a dropped ESC, CR, LF, DEL, home
    s = "\033[31m\344\270\200\033x\r\n\177\033[H";
    foreach (s[i]) row_plain(s[i]);
    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].b);
      if (directed_rows[i].typed) begin
        e = screen_cmds_q[$];
        if (e.kind != directed_rows[i].k || e.row != directed_rows[i].r ||
            e.col != directed_rows[i].c || e.codepoint != directed_rows[i].cp ||
            e.cell_width != directed_rows[i].w || e.mode_on != directed_rows[i].m)
          report("directed row kind", directed_rows[i].k, e.kind);
      end
    end
    drain();

    // Random traffic over several screen sizes
    foreach (sizes[p]) begin
      write_reg(CfgRows, sizes[p].nrows);
      write_reg(CfgCols, sizes[p].ncols);
      if (p == 2) begin
        // Hold the output long while bytes keep coming, to fill the queue
        hold_left = 400;
        run_random(40, 1'b1);
        run_random(40, 1'b0);
      end else if (p == 4) begin
        run_random(40, 1'b0);
        drain();
        run_random(40, 1'b0);
      end else begin
        if (p == 5) idle_on = 1'b0;
        run_random(80, 1'b0);
      end
      drain();
    end
    write_reg(CfgRows, 9'd24);
    write_reg(CfgCols, 9'd80);

    $display("sent %0d bytes, checked %0d results (%0d scrolls, %0d wide cells, %0d modes)",
             bytes_sent, checked, scrolls_seen, wides_seen, modes_seen);
    $display("screen sizes from 1x1 to 256x256 with clamped register values, %0d mismatches",
             mismatches);
    if (mismatches == 0 && screen_cmds_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/tbi_pkg.sv
rtl/core/tbi_core.sv
rtl/core/terminal_byte_interpreter.sv
bench/terminal_byte_interpreter_test.sv
